[rtl/core/dtn_pkg.sv]
// Shared constants and types for the decimal to negabinary converter.
`default_nettype none
package dtn_pkg;

	localparam int MAX_DIGITS = 16;
	localparam int MAX_BITS   = 56;

	localparam int DIGIT_W = 4;
	localparam int DCNT_W  = $clog2(MAX_DIGITS + 1);
	localparam int BCNT_W  = $clog2(MAX_BITS + 1);

	localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(9);
	localparam logic [DIGIT_W-1:0] HALF_ADD  = DIGIT_W'(5);

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_CONVERT,
		ST_EMIT
	} dtn_state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_START,
		CELL_SHIFT,
		CELL_STEP
	} cell_op_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic push_bit;
	} stk_ctrl_t;

endpackage
`default_nettype wire

[rtl/core/dtn_cell.sv]
// One BCD digit cell of the working value: load, shift, halve and increment.
`default_nettype none
module dtn_cell import dtn_pkg::*; (
	input  wire logic               clk,
	input  wire cell_op_t           op,
	input  wire logic [DIGIT_W-1:0] start_in,
	input  wire logic [DIGIT_W-1:0] shift_in,
	input  wire logic               upper_lsb,
	input  wire logic               carry_in,
	output logic      [DIGIT_W-1:0] digit,
	output logic                    carry_out
);

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] half;
	logic [DIGIT_W-1:0] step_val;

	// halve with borrow of five from the odd upper neighbor, then add carry
	always_comb begin
		half      = {1'b0, digit_q[DIGIT_W-1:1]} + (upper_lsb ? HALF_ADD : '0);
		carry_out = carry_in && (half == DIGIT_MAX);
		if (!carry_in) begin
			step_val = half;
		end else if (half == DIGIT_MAX) begin
			step_val = '0;
		end else begin
			step_val = half + DIGIT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			CELL_START: digit_q <= start_in;
			CELL_SHIFT: digit_q <= shift_in;
			CELL_STEP:  digit_q <= step_val;
			default:    digit_q <= digit_q;
		endcase
	end

	assign digit = digit_q;

endmodule
`default_nettype wire

[rtl/core/dtn_bit_stack.sv]
// Last-in first-out shift line holding the negabinary digits.
`default_nettype none
module dtn_bit_stack import dtn_pkg::*; (
	input  wire logic      clk,
	input  wire stk_ctrl_t ctrl,
	output logic           top_bit
);

	logic [MAX_BITS-1:0] stk_q;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			stk_q <= {stk_q[MAX_BITS-2:0], ctrl.push_bit};
		end else if (ctrl.pop) begin
			stk_q <= {1'b0, stk_q[MAX_BITS-1:1]};
		end
	end

	assign top_bit = stk_q[0];

endmodule
`default_nettype wire

[rtl/core/decimal_to_negabinary_top.sv]
// Top level of the decimal to negabinary converter.
`default_nettype none
// Takes a signed decimal number one digit per input word, most significant
// first, sign in s_tuser on the first word and s_tlast on the least
// significant digit; digits above nine count as nine. Up to MAX_DIGITS digits
// shift into a row of BCD cells. After the last digit the row halves itself
// once per cycle (with the negabinary correction) until it reaches zero, and
// the digits are then sent most significant first, one per output word, with
// m_tlast on the last one. A zero value gives a single 0. More than MAX_DIGITS
// digits, or a result of more than MAX_BITS digits, gives one word with
// m_tuser set. One number at a time: n input words, then the conversion
// through the cell row for a k-digit result, then k output words;
// input is held off from the last digit until the last output word is taken.
module decimal_to_negabinary_top import dtn_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [3:0] digit, [7:4] zero
	input  wire logic       s_tuser,   // [0] negative
	input  wire logic       s_tlast,   // final_digit
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic      [7:0] m_tdata,   // [0] nega_bit, [7:1] zero
	output logic            m_tuser,   // [0] too_long
	output logic            m_tlast    // end_of_number
);

	dtn_state_t          state_q, state_d;
	logic [DCNT_W-1:0]   digit_count_q, digit_count_d;
	logic                sign_q, sign_d;
	logic                overflow_q, overflow_d;
	logic                sgn_q, sgn_d;
	logic [BCNT_W-1:0]   bit_count_q, bit_count_d;
	logic                special_q, special_d;
	logic                fail_q, fail_d;

	cell_op_t            cell_op;
	stk_ctrl_t           stk_ctrl;
	logic                top_bit;
	logic [DIGIT_W-1:0]  in_digit;
	logic                in_acc;
	logic                out_acc;
	logic                full;
	logic                work_zero;
	logic                work_lsb;

	logic [DIGIT_W-1:0]  w     [MAX_DIGITS];
	logic [DIGIT_W-1:0]  sh_in [MAX_DIGITS];
	logic [DIGIT_W-1:0]  st_in [MAX_DIGITS];
	logic                up_lsb[MAX_DIGITS];
	logic [MAX_DIGITS:0] carry;

	assign in_digit = (s_tdata[DIGIT_W-1:0] > DIGIT_MAX) ? DIGIT_MAX : s_tdata[DIGIT_W-1:0];
	assign in_acc   = s_tvalid && s_tready;
	assign out_acc  = m_tvalid && m_tready;
	assign full     = overflow_q || (digit_count_q >= DCNT_W'(MAX_DIGITS));
	assign work_lsb = w[0][0];
	assign carry[0] = sgn_q && work_lsb;

	always_comb begin
		work_zero = 1'b1;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			sh_in[i]  = (i == 0) ? in_digit : w[(i == 0) ? 0 : i - 1];
			st_in[i]  = (i == 0) ? in_digit : '0;
			up_lsb[i] = (i == MAX_DIGITS - 1) ? 1'b0 : w[(i == MAX_DIGITS - 1) ? i : i + 1][0];
			if (w[i] != '0) begin
				work_zero = 1'b0;
			end
		end
	end

	for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
		dtn_cell u_cell (
			.clk       (clk),
			.op        (cell_op),
			.start_in  (st_in[g]),
			.shift_in  (sh_in[g]),
			.upper_lsb (up_lsb[g]),
			.carry_in  (carry[g]),
			.digit     (w[g]),
			.carry_out (carry[g+1])
		);
	end

	dtn_bit_stack u_stack (
		.clk     (clk),
		.ctrl    (stk_ctrl),
		.top_bit (top_bit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_COLLECT;
			digit_count_q <= '0;
			sign_q        <= 1'b0;
			overflow_q    <= 1'b0;
			sgn_q         <= 1'b0;
			bit_count_q   <= '0;
			special_q     <= 1'b0;
			fail_q        <= 1'b0;
		end else begin
			state_q       <= state_d;
			digit_count_q <= digit_count_d;
			sign_q        <= sign_d;
			overflow_q    <= overflow_d;
			sgn_q         <= sgn_d;
			bit_count_q   <= bit_count_d;
			special_q     <= special_d;
			fail_q        <= fail_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		digit_count_d = digit_count_q;
		sign_d        = sign_q;
		overflow_d    = overflow_q;
		sgn_d         = sgn_q;
		bit_count_d   = bit_count_q;
		special_d     = special_q;
		fail_d        = fail_q;
		cell_op       = CELL_HOLD;
		stk_ctrl      = '0;
		s_tready      = 1'b0;
		m_tvalid      = 1'b0;

		case (state_q)
			ST_COLLECT: begin
				s_tready = 1'b1;
				if (in_acc) begin
					if (digit_count_q == '0 && !overflow_q) begin
						sign_d = s_tuser;
					end
					if (full) begin
						overflow_d = 1'b1;
					end else begin
						cell_op       = (digit_count_q == '0) ? CELL_START : CELL_SHIFT;
						digit_count_d = digit_count_q + DCNT_W'(1);
					end
					if (s_tlast) begin
						digit_count_d = '0;
						sign_d        = 1'b0;
						overflow_d    = 1'b0;
						bit_count_d   = '0;
						if (full) begin
							special_d = 1'b1;
							fail_d    = 1'b1;
							state_d   = ST_EMIT;
						end else begin
							sgn_d   = (digit_count_q == '0) ? s_tuser : sign_q;
							state_d = ST_CONVERT;
						end
					end
				end
			end
			ST_CONVERT: begin
				if (work_zero) begin
					special_d = (bit_count_q == '0);
					fail_d    = 1'b0;
					state_d   = ST_EMIT;
				end else if (bit_count_q >= BCNT_W'(MAX_BITS)) begin
					special_d   = 1'b1;
					fail_d      = 1'b1;
					bit_count_d = '0;
					state_d     = ST_EMIT;
				end else begin
					stk_ctrl.push     = 1'b1;
					stk_ctrl.push_bit = work_lsb;
					cell_op           = CELL_STEP;
					bit_count_d       = bit_count_q + BCNT_W'(1);
					sgn_d             = !sgn_q;
				end
			end
			ST_EMIT: begin
				m_tvalid = 1'b1;
				if (out_acc) begin
					if (special_q || bit_count_q == BCNT_W'(1)) begin
						bit_count_d = '0;
						special_d   = 1'b0;
						fail_d      = 1'b0;
						state_d     = ST_COLLECT;
					end else begin
						stk_ctrl.pop = 1'b1;
						bit_count_d  = bit_count_q - BCNT_W'(1);
					end
				end
			end
			default: begin
				state_d = ST_COLLECT;
			end
		endcase
	end

	assign m_tdata = {7'd0, special_q ? 1'b0 : top_bit};
	assign m_tlast = special_q || (bit_count_q == BCNT_W'(1));
	assign m_tuser = special_q && fail_q;

`ifndef SYNTHESIS
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output open together");

	a_bits_fit: assert property (@(posedge clk) disable iff (!arst_n)
		bit_count_q <= BCNT_W'(MAX_BITS))
		else $error("digit count past stack depth");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !special_q) |-> (bit_count_q != '0))
		else $error("emitting from empty stack");

	a_final_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("input taken right after last digit");
`endif

endmodule
`default_nettype wire
